>>> hw/rtl/fbmd_pkg.sv
// fbmd_pkg: shared types and constants of the fbm image stream decoder
// no dependencies
`timescale 1ns / 1ps
package fbmd_pkg;

  typedef enum logic [2:0] {
    PH_NUM  = 3'd0,
    PH_TEXT = 3'd1,
    PH_PAL  = 3'd2,
    PH_DATA = 3'd3,
    PH_DONE = 3'd4,
    PH_FAIL = 3'd5
  } phase_t;

  localparam logic [1:0] KIND_PIXEL  = 2'd0;
  localparam logic [1:0] KIND_HEADER = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  localparam logic [3:0] ERR_NONE     = 4'd0;
  localparam logic [3:0] ERR_NEGATIVE = 4'd1;
  localparam logic [3:0] ERR_TOO_LONG = 4'd2;
  localparam logic [3:0] ERR_PLANES   = 4'd3;
  localparam logic [3:0] ERR_PHYSBITS = 4'd4;
  localparam logic [3:0] ERR_RGB_TBL  = 4'd5;
  localparam logic [3:0] ERR_ROW      = 4'd6;
  localparam logic [3:0] ERR_PLANE    = 4'd7;
  localparam logic [3:0] ERR_GEOMETRY = 4'd8;
  localparam logic [3:0] ERR_COLORS   = 4'd9;

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_MINUS = 8'h2d;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam int unsigned PHYS_BITS = 8;

  // one result item
  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  error_code;
    logic [12:0] image_width;
    logic [12:0] image_height;
    logic [23:0] pixel_index;
    logic [1:0]  plane_sel;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        last;
  } result_t;

endpackage

>>> hw/rtl/fbmd_hdr_check.sv
// fbmd_hdr_check: geometry and table checks on the parsed header
// pipelined while the second text field is skipped; uses fbmd_pkg
`timescale 1ns / 1ps
module fbmd_hdr_check #(
  parameter int unsigned MAX_SIDE = 4096,
  parameter int unsigned PALETTE_DEPTH = 256
) (
  input  logic        clk,
  input  logic [31:0] width,
  input  logic [31:0] height,
  input  logic [31:0] planes,
  input  logic [31:0] physbits,
  input  logic [31:0] rowlen,
  input  logic [31:0] plnlen,
  input  logic [31:0] clrlen,
  output logic [3:0]  code,
  output logic [8:0]  ncolors
);
  import fbmd_pkg::*;

  // stage 1: the two products, split into 16-bit partial products
  logic [47:0] len_lo_r, len_hi_r, rl_lo_r, rl_hi_r;
  logic [31:0] hm1;
  logic [63:0] len, rowspan;
  logic [31:0] q3_r;
  logic [1:0]  r3_r;
  logic [33:0] q3_prod;

  assign hm1 = height - 32'd1;

  always_ff @(posedge clk) begin
    len_lo_r <= width * {16'd0, height[15:0]};
    len_hi_r <= width * {16'd0, height[31:16]};
    rl_lo_r  <= rowlen * {16'd0, hm1[15:0]};
    rl_hi_r  <= rowlen * {16'd0, hm1[31:16]};
  end

  // clrlen / 3 by reciprocal: clrlen only matters up to 3*PALETTE_DEPTH
  always_comb begin
    q3_prod = {24'd0, clrlen[9:0]} * 34'd43691;
  end
  always_ff @(posedge clk) begin
    if (clrlen > 32'd1023) begin
      q3_r <= 32'hffff_ffff;
      r3_r <= 2'd1;
    end else begin
      q3_r <= {15'd0, q3_prod[33:17]};
      r3_r <= 2'(clrlen[9:0] - 10'(q3_prod[33:17] * 3));
    end
  end

  assign len     = {16'd0, len_lo_r} + {len_hi_r, 16'd0};
  assign rowspan = {16'd0, rl_lo_r} + {rl_hi_r, 16'd0} + {32'd0, width};

  // stage 2: compares
  logic        c_pl_r, c_ph_r, c_rgb_r, c_row_r, c_len_r, c_zero_r, c_span_r, c_side_r;
  logic        mapped_r, c_clr_r;
  logic [31:0] q3_d_r;
  always_ff @(posedge clk) begin
    c_pl_r   <= (planes != 32'd1) && (planes != 32'd3);
    c_ph_r   <= physbits != 32'(PHYS_BITS);
    c_rgb_r  <= (planes == 32'd3) && (clrlen != 32'd0);
    c_row_r  <= width > rowlen;
    c_len_r  <= len > {32'd0, plnlen};
    c_zero_r <= len == 64'd0;
    c_span_r <= rowspan > {32'd0, plnlen};
    c_side_r <= (width > 32'(MAX_SIDE)) || (height > 32'(MAX_SIDE));
    mapped_r <= planes == 32'd1;
    c_clr_r  <= (clrlen == 32'd0) || (r3_r != 2'd0) || (q3_r > 32'(PALETTE_DEPTH));
    q3_d_r   <= q3_r;
  end

  always_comb begin
    code = ERR_NONE;
    ncolors = 9'd0;
    if (c_pl_r) code = ERR_PLANES;
    else if (c_ph_r) code = ERR_PHYSBITS;
    else if (c_rgb_r) code = ERR_RGB_TBL;
    else if (c_row_r) code = ERR_ROW;
    else if (c_len_r) code = ERR_PLANE;
    else if (c_zero_r) code = ERR_GEOMETRY;
    else if (c_span_r) code = ERR_PLANE;
    else if (c_side_r) code = ERR_GEOMETRY;
    else if (mapped_r && c_clr_r) code = ERR_COLORS;
    if (mapped_r) ncolors = q3_d_r[8:0];
  end
endmodule

>>> hw/rtl/fbm_image_stream_decoder_core.sv
// fbm_image_stream_decoder_core: top level of the fbm byte stream decoder
// an accepted byte goes through the pending stage, then the output register, to its result
// one byte per cycle unless a held result stalls in_ready; the palette is a 256x24 memory with a registered read
// a data byte looks up the palette in the accept cycle, the pixel is formed from the read data
// reset: synchronous active-low rst_n clears the parser state; the palette is not cleared
// a halted decoder (after the image or an error) swallows bytes until reset
`timescale 1ns / 1ps
module fbm_image_stream_decoder_core #(
  parameter int unsigned MAX_SIDE = 4096,
  parameter int unsigned FIELD_CHARS = 64,
  parameter int unsigned PALETTE_DEPTH = 256,
  parameter int unsigned TEXT_BYTES = 80
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [3:0]  out_error_code,
  output logic [12:0] out_image_width,
  output logic [12:0] out_image_height,
  output logic [23:0] out_pixel_index,
  output logic [1:0]  out_plane_sel,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic        out_last
);
  import fbmd_pkg::*;

  localparam int unsigned PAW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

  // output register with a pending pixel stage; the stage advances when
  // the result register is empty or being drained
  logic    advance;
  logic    res_valid_r;
  result_t res_r;

  // stage a: pixel request waiting on the palette read
  logic        pa_valid_r, pa_valid_nxt;
  logic        pa_mapped_r, pa_hit_r;
  result_t     pa_res_r, pa_res_nxt;
  logic        pa_hit_nxt, pa_mapped_nxt;

  assign in_ready  = !res_valid_r || out_ready;
  assign advance   = in_ready;

  // parser state
  phase_t      phase_r, phase_nxt;
  logic [3:0]  field_r, field_nxt;
  logic [31:0] numval_r, numval_nxt;
  logic [6:0]  chars_r, chars_nxt;
  logic [7:0]  text_r, text_nxt;
  logic [31:0] hdr_r [9];
  logic [8:0]  ncol_r, ncol_nxt;
  logic [1:0]  chan_r, chan_nxt;
  logic [31:0] col_r, col_nxt;
  logic [12:0] row_r, row_nxt;
  logic [31:0] poff_r, poff_nxt;
  logic [23:0] rowbase_r, rowbase_nxt;
  logic        fail_now;
  logic [3:0]  fail_code;
  logic        hdr_wr;

  logic [3:0]  chk_code;
  logic [8:0]  chk_ncol;

  fbmd_hdr_check #(.MAX_SIDE(MAX_SIDE), .PALETTE_DEPTH(PALETTE_DEPTH)) u_check (
    .clk(clk), .width(hdr_r[0]), .height(hdr_r[1]), .planes(hdr_r[2]),
    .physbits(hdr_r[4]), .rowlen(hdr_r[5]), .plnlen(hdr_r[6]), .clrlen(hdr_r[7]),
    .code(chk_code), .ncolors(chk_ncol)
  );

  // palette memory, one 8-bit lane per color plane
  logic [7:0]     pal_mem [3][PALETTE_DEPTH];
  logic           pal_we;
  logic [PAW-1:0] pal_waddr, pal_raddr;
  logic [7:0]     pal_r, pal_g, pal_b;

  always_ff @(posedge clk) begin
    if (pal_we) pal_mem[chan_r][pal_waddr] <= in_data_byte;
    if (advance) begin
      pal_r <= pal_mem[0][pal_raddr];
      pal_g <= pal_mem[1][pal_raddr];
      pal_b <= pal_mem[2][pal_raddr];
    end
  end

  logic        acc;
  logic [35:0] mul10;
  logic [35:0] digit_sum;
  logic [31:0] w32, h32;
  logic        endpix;

  assign acc = in_valid && in_ready;
  assign w32 = hdr_r[0];
  assign h32 = hdr_r[1];
  assign pal_raddr = PAW'(in_data_byte);
  assign pal_waddr = PAW'(col_r);
  assign mul10 = {numval_r, 3'd0} + {2'd0, numval_r, 1'd0};
  assign digit_sum = {1'b0, mul10[34:0]} + 36'(in_data_byte - CHAR_ZERO);
  assign endpix = ({19'd0, row_r} == h32 - 32'd1) && (col_r == w32 - 32'd1);

  always_comb begin
    phase_nxt = phase_r;
    field_nxt = field_r;
    numval_nxt = numval_r;
    chars_nxt = chars_r;
    text_nxt = text_r;
    ncol_nxt = ncol_r;
    chan_nxt = chan_r;
    col_nxt = col_r;
    row_nxt = row_r;
    poff_nxt = poff_r;
    rowbase_nxt = rowbase_r;
    fail_now = 1'b0;
    fail_code = ERR_NONE;
    hdr_wr = 1'b0;
    pal_we = 1'b0;
    pa_valid_nxt = 1'b0;
    pa_res_nxt = '0;
    pa_hit_nxt = 1'b0;
    pa_mapped_nxt = 1'b0;
    if (acc) begin
      case (phase_r)
        PH_NUM: begin
          if (in_data_byte == CHAR_NUL) begin
            hdr_wr = 1'b1;
            numval_nxt = '0;
            chars_nxt = '0;
            if (field_r >= 4'd8) begin
              phase_nxt = PH_TEXT;
              field_nxt = 4'd9;
              text_nxt = '0;
            end else begin
              field_nxt = field_r + 4'd1;
            end
          end else if (in_data_byte == CHAR_MINUS) begin
            fail_now = 1'b1;
            fail_code = ERR_NEGATIVE;
          end else begin
            if (in_data_byte >= CHAR_ZERO && in_data_byte <= CHAR_NINE) begin
              // saturate the accumulator
              if (mul10[35] || numval_r > 32'd429496729 || digit_sum[35:32] != 4'd0)
                numval_nxt = 32'hffff_ffff;
              else
                numval_nxt = digit_sum[31:0];
            end else begin
              numval_nxt = '0;
            end
            chars_nxt = chars_r + 7'd1;
            if ({25'd0, chars_nxt} >= 32'(FIELD_CHARS)) begin
              fail_now = 1'b1;
              fail_code = ERR_TOO_LONG;
            end
          end
        end
        PH_TEXT: begin
          text_nxt = text_r + 8'd1;
          if ({24'd0, text_nxt} >= 32'(TEXT_BYTES)) begin
            text_nxt = '0;
            if (field_r == 4'd9) begin
              field_nxt = 4'd10;
            end else if (chk_code != ERR_NONE) begin
              fail_now = 1'b1;
              fail_code = chk_code;
            end else begin
              pa_valid_nxt = 1'b1;
              pa_res_nxt.kind = KIND_HEADER;
              pa_res_nxt.image_width = w32[12:0];
              pa_res_nxt.image_height = h32[12:0];
              ncol_nxt = chk_ncol;
              chan_nxt = '0;
              col_nxt = '0;
              row_nxt = '0;
              poff_nxt = '0;
              rowbase_nxt = '0;
              phase_nxt = (hdr_r[2] == 32'd1) ? PH_PAL : PH_DATA;
            end
          end
        end
        PH_PAL: begin
          pal_we = col_r < {23'd0, ncol_r};
          col_nxt = col_r + 32'd1;
          if (col_nxt >= {23'd0, ncol_r}) begin
            col_nxt = '0;
            if (chan_r == 2'd2) begin
              chan_nxt = '0;
              phase_nxt = PH_DATA;
            end else begin
              chan_nxt = chan_r + 2'd1;
            end
          end
        end
        PH_DATA: begin
          if ({19'd0, row_r} < h32 && col_r < w32) begin
            pa_valid_nxt = 1'b1;
            pa_res_nxt.kind = KIND_PIXEL;
            pa_res_nxt.image_width = w32[12:0];
            pa_res_nxt.image_height = h32[12:0];
            pa_res_nxt.pixel_index = rowbase_r + col_r[23:0];
            if (hdr_r[2] == 32'd1) begin
              pa_mapped_nxt = 1'b1;
              pa_hit_nxt = {1'b0, in_data_byte} < ncol_r;
              pa_res_nxt.plane_sel = 2'd3;
              pa_res_nxt.last = endpix;
            end else begin
              pa_res_nxt.plane_sel = chan_r;
              pa_res_nxt.red = in_data_byte;
              pa_res_nxt.last = endpix && (chan_r == 2'd2);
            end
          end
          col_nxt = col_r + 32'd1;
          if (col_nxt >= hdr_r[5]) begin
            col_nxt = '0;
            if ({19'd0, row_r} < h32) begin
              row_nxt = row_r + 13'd1;
              rowbase_nxt = rowbase_r + w32[23:0];
            end
          end
          poff_nxt = poff_r + 32'd1;
          if (poff_nxt >= hdr_r[6]) begin
            poff_nxt = '0;
            col_nxt = '0;
            row_nxt = '0;
            rowbase_nxt = '0;
            if (hdr_r[2] == 32'd1 || chan_r >= 2'd2) phase_nxt = PH_DONE;
            else chan_nxt = chan_r + 2'd1;
          end
        end
        default: ;
      endcase
      if (fail_now) begin
        phase_nxt = PH_FAIL;
        pa_valid_nxt = 1'b1;
        pa_res_nxt = '0;
        pa_res_nxt.kind = KIND_ERROR;
        pa_res_nxt.error_code = fail_code;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_NUM;
      field_r <= '0;
      numval_r <= '0;
      chars_r <= '0;
      text_r <= '0;
      ncol_r <= '0;
      chan_r <= '0;
      col_r <= '0;
      row_r <= '0;
      poff_r <= '0;
      rowbase_r <= '0;
      for (int i = 0; i < 9; i++) hdr_r[i] <= '0;
    end else begin
      phase_r <= phase_nxt;
      field_r <= field_nxt;
      numval_r <= numval_nxt;
      chars_r <= chars_nxt;
      text_r <= text_nxt;
      ncol_r <= ncol_nxt;
      chan_r <= chan_nxt;
      col_r <= col_nxt;
      row_r <= row_nxt;
      poff_r <= poff_nxt;
      rowbase_r <= rowbase_nxt;
      if (hdr_wr) hdr_r[field_r] <= numval_r;
    end
  end

  // pending stage and result register move together on advance
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pa_valid_r <= 1'b0;
      res_valid_r <= 1'b0;
    end else if (advance) begin
      pa_valid_r <= pa_valid_nxt;
      res_valid_r <= pa_valid_r;
    end
  end

  result_t pix;
  always_comb begin
    pix = pa_res_r;
    if (pa_mapped_r) begin
      pix.red = pa_hit_r ? pal_r : 8'd0;
      pix.green = pa_hit_r ? pal_g : 8'd0;
      pix.blue = pa_hit_r ? pal_b : 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pa_res_r <= pa_res_nxt;
      pa_hit_r <= pa_hit_nxt;
      pa_mapped_r <= pa_mapped_nxt;
      res_r <= pix;
    end
  end

  assign out_valid = res_valid_r;
  assign out_kind = res_r.kind;
  assign out_error_code = res_r.error_code;
  assign out_image_width = res_r.image_width;
  assign out_image_height = res_r.image_height;
  assign out_pixel_index = res_r.pixel_index;
  assign out_plane_sel = res_r.plane_sel;
  assign out_red = res_r.red;
  assign out_green = res_r.green;
  assign out_blue = res_r.blue;
  assign out_last = res_r.last;
endmodule

>>> hw/rtl/fbmd_checker.sv
// fbmd_checker: port-level checks on the decoder and its bind
// depends on fbmd_pkg and the fbm_image_stream_decoder_core ports
`timescale 1ns / 1ps
module fbmd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_kind,
  input logic [3:0] out_error_code,
  input logic [7:0] out_green,
  input logic [1:0] out_plane_sel
);
  import fbmd_pkg::*;

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready) else $error("overrun");
  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_ERROR |-> out_error_code != ERR_NONE) else $error("no code");
  a_comp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_PIXEL && out_plane_sel != 2'd3 |-> out_green == 8'd0)
    else $error("component green");
endmodule

bind fbm_image_stream_decoder_core fbmd_checker u_fbmd_checker (
  .clk(clk), .rst_n(rst_n), .in_ready(in_ready), .out_valid(out_valid),
  .out_ready(out_ready), .out_kind(out_kind), .out_error_code(out_error_code),
  .out_green(out_green), .out_plane_sel(out_plane_sel)
);
